[rtl/trie_pkg.sv]
`default_nettype none

package trie_pkg;

   localparam int NODE_COUNT    = 4096;
   localparam int ALPHABET_SIZE = 26;
   localparam int COUNT_BITS    = 16;

   localparam int NODE_BITS     = $clog2(NODE_COUNT);
   localparam int SYM_IDX_BITS  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ROW_BITS      = ALPHABET_SIZE * NODE_BITS;
   localparam int WORD_BITS     = 16;

   typedef logic [NODE_BITS-1:0]                     node_type;
   typedef logic [ALPHABET_SIZE-1:0][NODE_BITS-1:0]  row_type;
   typedef logic [COUNT_BITS-1:0]                    count_type;
   typedef logic [WORD_BITS-1:0]                     word_type;

   localparam count_type COUNT_MAX = '1;
   localparam node_type  LAST_NODE = node_type'(NODE_COUNT - 1);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_PREFIX = 2'd1,
      REQ_WORD   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] symbol;
      logic       has_symbol;
      logic       first_symbol;
      logic       last_symbol;
   } req_item_type;

   typedef struct packed {
      logic     found;
      logic     table_full;
      word_type word_count;
   } rsp_item_type;

   function automatic word_type word_of(input count_type c);
      logic [32:0] w;
      w = 33'(c);
      if (w > 33'(17'h0FFFF)) begin
         return '1;
      end
      return w[WORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/trie_ram.sv]
`default_nettype none

module trie_ram #(
   parameter int DATA_BITS = 8,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/trie_insert_and_lookup_unit.sv]
// 26-way trie: insert and lookup of strings, one symbol per request transfer.
// Request channel (req_valid/req_ready/req_data): a string is a run of items
// framed by first_symbol and last_symbol; req_type selects insert, prefix
// search or whole-word search. An item with has_symbol 0 carries no symbol
// (an empty string is a single first+last item). req_type 3 is dropped.
// Response channel (rsp_valid/rsp_ready/rsp_data): one transfer per accepted
// last item, in order, giving found, table_full and the saturated end count.
// Steps: an item that carries a symbol on a live path does a child-table read,
// then the decision and write back; a last item whose path exists adds an
// end-count read-modify-write. A response is registered when its last item
// finishes. The child table (one 312-bit row per node) and the end-count
// memory are simple dual-port synchronous RAMs (one write, one read port).
// Reset: a clearing pass writes zeros to all 4096 node rows and counts,
// one node per cycle; req_ready stays low during it.
// Stall: a response waiting on rsp_ready sits in the output register; the
// block keeps taking items, parks the next response in a hold register and
// holds req_ready low until the output frees up.
`default_nettype none

module trie_insert_and_lookup_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire trie_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output trie_pkg::rsp_item_type     rsp_data
);

   import trie_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_COUNT,
      ST_HOLD
   } state_type;

   state_type    state_ff, state_in;
   node_type     clear_ff, clear_in;
   node_type     cursor_ff, cursor_in;
   node_type     nodes_used_ff, nodes_used_in;
   logic         missing_ff, missing_in;
   logic         full_ff, full_in;
   logic [1:0]   req_code_ff, req_code_in;
   logic [4:0]   sym_ff, sym_in;
   logic         last_ff, last_in;
   rsp_item_type hold_ff, hold_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic         child_we, child_re;
   node_type     child_waddr, child_raddr;
   row_type      child_wdata, child_rdata;
   logic         count_we, count_re;
   node_type     count_waddr, count_raddr;
   count_type    count_wdata, count_rdata;

   logic         produce;
   rsp_item_type result;
   node_type     cur;
   logic         miss;
   logic         full;
   node_type     child;
   node_type     new_node;
   count_type    cnt_next;
   logic [SYM_IDX_BITS-1:0] sym_idx;

   trie_ram #(
      .DATA_BITS (ROW_BITS),
      .ADDR_BITS (NODE_BITS)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_en   (child_re),
      .rd_addr (child_raddr),
      .rd_data (child_rdata)
   );

   trie_ram #(
      .DATA_BITS (COUNT_BITS),
      .ADDR_BITS (NODE_BITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (count_waddr),
      .wr_data (count_wdata),
      .rd_en   (count_re),
      .rd_addr (count_raddr),
      .rd_data (count_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign sym_idx   = SYM_IDX_BITS'(sym_ff);

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      cursor_in     = cursor_ff;
      nodes_used_in = nodes_used_ff;
      missing_in    = missing_ff;
      full_in       = full_ff;
      req_code_in   = req_code_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;

      child_we    = 1'b0;
      child_waddr = cursor_ff;
      child_wdata = child_rdata;
      child_re    = 1'b0;
      child_raddr = cursor_ff;
      count_we    = 1'b0;
      count_waddr = cursor_ff;
      count_wdata = count_rdata;
      count_re    = 1'b0;
      count_raddr = cursor_ff;

      produce  = 1'b0;
      result   = '0;
      cur      = cursor_ff;
      miss     = missing_ff;
      full     = full_ff;
      child    = child_rdata[sym_idx];
      new_node = nodes_used_ff + node_type'(1);
      cnt_next = (count_rdata == COUNT_MAX) ? count_rdata : count_rdata + count_type'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clear_ff;
            child_wdata = '0;
            count_we    = 1'b1;
            count_waddr = clear_ff;
            count_wdata = '0;
            clear_in    = clear_ff + node_type'(1);
            if (clear_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid && req_data.req_type != REQ_NONE) begin
               if (req_data.first_symbol) begin
                  cur  = '0;
                  miss = 1'b0;
                  full = 1'b0;
               end
               req_code_in = req_data.req_type;
               sym_in      = req_data.symbol;
               last_in     = req_data.last_symbol;
               cursor_in   = cur;
               missing_in  = miss;
               full_in     = full;
               if (req_data.has_symbol && !miss &&
                   32'(req_data.symbol) >= 32'(ALPHABET_SIZE)) begin
                  miss       = 1'b1;
                  missing_in = 1'b1;
               end
               if (req_data.has_symbol && !miss) begin
                  child_re    = 1'b1;
                  child_raddr = cur;
                  state_in    = ST_WALK;
               end else if (req_data.last_symbol) begin
                  if (!miss) begin
                     count_re    = 1'b1;
                     count_raddr = cur;
                     state_in    = ST_COUNT;
                  end else begin
                     produce    = 1'b1;
                     result     = '{found: 1'b0, table_full: full, word_count: '0};
                     cursor_in  = '0;
                     missing_in = 1'b0;
                     full_in    = 1'b0;
                  end
               end
            end
         end

         ST_WALK: begin
            miss = 1'b0;
            if (child != '0) begin
               cur = child;
            end else if (req_code_ff != REQ_INSERT) begin
               miss = 1'b1;
            end else if (nodes_used_ff >= LAST_NODE) begin
               miss = 1'b1;
               full = 1'b1;
            end else begin
               nodes_used_in        = new_node;
               child_we             = 1'b1;
               child_waddr          = cursor_ff;
               child_wdata          = child_rdata;
               child_wdata[sym_idx] = new_node;
               cur                  = new_node;
            end
            state_in   = ST_IDLE;
            cursor_in  = cur;
            missing_in = miss;
            full_in    = full;
            if (last_ff) begin
               if (!miss) begin
                  count_re    = 1'b1;
                  count_raddr = cur;
                  state_in    = ST_COUNT;
               end else begin
                  produce    = 1'b1;
                  result     = '{found: 1'b0, table_full: full, word_count: '0};
                  cursor_in  = '0;
                  missing_in = 1'b0;
                  full_in    = 1'b0;
               end
            end
         end

         ST_COUNT: begin
            produce = 1'b1;
            case (req_code_ff)
               REQ_INSERT: begin
                  count_we    = 1'b1;
                  count_waddr = cursor_ff;
                  count_wdata = cnt_next;
                  result      = '{found: 1'b0, table_full: full_ff,
                                  word_count: word_of(cnt_next)};
               end
               REQ_PREFIX: begin
                  result = '{found: 1'b1, table_full: full_ff,
                             word_count: word_of(count_rdata)};
               end
               default: begin
                  result = '{found: (count_rdata != '0), table_full: full_ff,
                             word_count: word_of(count_rdata)};
               end
            endcase
            state_in   = ST_IDLE;
            cursor_in  = '0;
            missing_in = 1'b0;
            full_in    = 1'b0;
         end

         ST_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (produce) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            hold_in  = result;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ff      <= '0;
         cursor_ff     <= '0;
         nodes_used_ff <= '0;
         missing_ff    <= 1'b0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         cursor_ff     <= cursor_in;
         nodes_used_ff <= nodes_used_in;
         missing_ff    <= missing_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_code_ff <= req_code_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[rtl/trie_checker.sv]
`default_nettype none

module trie_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire trie_pkg::req_item_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire trie_pkg::rsp_item_type rsp_data
);

   import trie_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // drop responses across reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold off requests while the tables clear
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

   // a failed allocation leaves no path
   a_full_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> !rsp_data.found && rsp_data.word_count == '0)
      else $error("table full response reports a hit");

endmodule

bind trie_insert_and_lookup_unit trie_checker u_trie_checker (.*);

`default_nettype wire

[tb/trie_insert_and_lookup_unit_tb.sv]
`default_nettype none

module trie_insert_and_lookup_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trie_pkg::*;

   localparam longint COUNT_TOP   = (longint'(1) << COUNT_BITS) - 1;
   localparam int     CYCLE_LIMIT = 5000000;
   localparam int     RANDOM_ITEMS = 1575;

   typedef struct packed {
      logic [3:0]      len;
      logic [7:0][4:0] sym;
   } word_rec_type;

   class trie_mirror;
      bit [NODE_BITS-1:0] child_of [NODE_COUNT*ALPHABET_SIZE];
      longint             ends_at [NODE_COUNT];
      int                 nodes_used;
      int                 cursor;
      bit                 path_missing;
      bit                 full_seen;
      rsp_item_type       answers_due[$];
      int                 answers_total;
      int                 found_total;
      int                 full_total;
      int                 saturated_total;
      int                 mismatches;

      function void restart_walk();
         cursor       = 0;
         path_missing = 1'b0;
         full_seen    = 1'b0;
      endfunction

      function void step_symbol(req_code_type op, logic [4:0] sym);
         int slot;
         int nxt;
         if (path_missing) return;
         if (sym >= ALPHABET_SIZE) begin
            path_missing = 1'b1;
            return;
         end
         slot = cursor * ALPHABET_SIZE + int'(sym);
         nxt  = int'(child_of[slot]);
         if (nxt == 0) begin
            if (op != REQ_INSERT) begin
               path_missing = 1'b1;
               return;
            end
            if (nodes_used + 1 >= NODE_COUNT) begin
               path_missing = 1'b1;
               full_seen    = 1'b1;
               return;
            end
            nodes_used++;
            nxt = nodes_used;
            child_of[slot] = node_type'(nxt);
         end
         cursor = nxt;
      endfunction

      function void take_request(req_item_type it);
         req_code_type op;
         rsp_item_type want;
         longint       cnt;
         op = req_code_type'(it.req_type);
         if (op == REQ_NONE) return;
         if (it.first_symbol) restart_walk();
         if (it.has_symbol) step_symbol(op, it.symbol);
         if (!it.last_symbol) return;
         want = '0;
         cnt  = 0;
         if (!path_missing) begin
            cnt = ends_at[cursor];
            case (op)
               REQ_INSERT: begin
                  if (cnt < COUNT_TOP) cnt++;
                  ends_at[cursor] = cnt;
               end
               REQ_PREFIX: want.found = 1'b1;
               default:    want.found = (cnt != 0);
            endcase
         end
         want.table_full = full_seen;
         want.word_count = (cnt > 64'hFFFF) ? '1 : word_type'(cnt);
         answers_due = {answers_due, want};
         answers_total++;
         if (want.found) found_total++;
         if (want.table_full) full_total++;
         if (cnt == COUNT_TOP) saturated_total++;
         restart_walk();
      endfunction

      function void check_answer(rsp_item_type got);
         rsp_item_type want;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: found=%0b table_full=%0b word_count=%0d",
                        got.found, got.table_full, got.word_count);
            return;
         end
         want = answers_due.pop_front();
         if (got.found !== want.found || got.table_full !== want.table_full ||
             got.word_count !== want.word_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected found=%0b table_full=%0b word_count=%0d, %s",
                        want.found, want.table_full, want.word_count,
                        $sformatf("got found=%0b table_full=%0b word_count=%0d",
                                  got.found, got.table_full, got.word_count));
         end
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   trie_mirror   mirror;
   bit           stall_on = 1'b1;
   int           item_count = 0;
   int           cycle_count = 0;
   word_rec_type dict[$];

   trie_insert_and_lookup_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = !stall_on || ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) mirror.check_answer(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("trie_insert_and_lookup_unit regression: fail");
         $finish;
      end
   end

   function automatic req_item_type make_item(req_code_type op, int sym, bit has,
                                              bit first, bit last);
      req_item_type it;
      it.req_type     = op;
      it.symbol       = 5'(sym);
      it.has_symbol   = has;
      it.first_symbol = first;
      it.last_symbol  = last;
      return it;
   endfunction

   function automatic word_rec_type random_word();
      word_rec_type w;
      bit           narrow;
      narrow = 1'($urandom_range(1));
      w.len  = ($urandom_range(3) == 0) ? 4'($urandom_range(8)) : 4'($urandom_range(4));
      for (int i = 0; i < 8; i++)
         w.sym[i] = narrow ? 5'($urandom_range(3)) : 5'($urandom_range(25));
      return w;
   endfunction

   task automatic send_item(input req_item_type it);
      while (stall_on && $urandom_range(99) < 17) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (!req_ready);
      mirror.take_request(it);
      if (it.req_type != REQ_NONE) item_count++;
      @(negedge clock);
   endtask

   task automatic send_noise();
      send_item(make_item(REQ_NONE, $urandom_range(31), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1))));
   endtask

   task automatic send_word(input req_code_type op, input word_rec_type w, input bit noisy);
      req_item_type it;
      int           n;
      bit           drop_first;
      bit           drop_last;
      n          = (w.len == 0) ? 1 : int'(w.len);
      drop_first = noisy && ($urandom_range(99) < 5);
      drop_last  = noisy && ($urandom_range(99) < 3);
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(99) < 3) send_noise();
         if (noisy && $urandom_range(99) < 4)
            send_item(make_item(op, $urandom_range(31), 1'b0, 1'b0, 1'b0));
         it = make_item(op, w.sym[i], w.len != 0, (i == 0) && !drop_first,
                        (i == n - 1) && !drop_last);
         if (w.len == 0) it.symbol = 5'($urandom_range(31));
         if (noisy && $urandom_range(99) < 5) it.req_type = 2'($urandom_range(2));
         if (noisy && w.len != 0 && $urandom_range(99) < 3)
            it.symbol = 5'($urandom_range(31, 26));
         send_item(it);
      end
   endtask

   task automatic send_random(input int count, input bit quiet_middle);
      int           stop_at;
      int           start_at;
      int           roll;
      req_code_type op;
      word_rec_type w;
      start_at = item_count;
      stop_at  = item_count + count;
      while (item_count < stop_at) begin
         stall_on = !(quiet_middle && item_count >= start_at + count * 3 / 8 &&
                      item_count < start_at + count * 9 / 16);
         roll = $urandom_range(99);
         if (roll < 40) op = REQ_INSERT;
         else if (roll < 70) op = REQ_PREFIX;
         else op = REQ_WORD;
         if (op != REQ_INSERT && dict.size() > 0 && $urandom_range(99) < 60) begin
            w = dict[$urandom_range(dict.size() - 1)];
            if (op == REQ_PREFIX && w.len > 0) w.len = 4'($urandom_range(w.len));
            else if ($urandom_range(3) == 0 && w.len < 8) w.len = w.len + 4'd1;
         end else begin
            w = random_word();
         end
         if (op == REQ_INSERT) begin
            if (dict.size() < 64) dict = {dict, w};
            else dict[$urandom_range(63)] = w;
         end
         send_word(op, w, 1'b1);
      end
      stall_on = 1'b1;
   endtask

   initial begin
      mirror = new;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(make_item(REQ_WORD,   0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(REQ_PREFIX, 31, 1'b0, 1'b1, 1'b1));
      send_item(make_item(REQ_INSERT, 25, 1'b1, 1'b1, 1'b0));
      send_item(make_item(REQ_INSERT, 25, 1'b1, 1'b0, 1'b1));
      send_item(make_item(REQ_PREFIX, 25, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_WORD,   25, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_WORD,   25, 1'b1, 1'b1, 1'b0));
      send_item(make_item(REQ_WORD,   25, 1'b1, 1'b0, 1'b1));
      send_item(make_item(REQ_INSERT, 0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(REQ_WORD,   0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(REQ_INSERT, 0, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_INSERT, 0, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_INSERT, 31, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_PREFIX, 26, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_NONE,   31, 1'b1, 1'b1, 1'b1));
      send_item(make_item(REQ_INSERT, 1, 1'b1, 1'b1, 1'b0));
      send_item(make_item(REQ_PREFIX, 2, 1'b1, 1'b0, 1'b1));
      send_item(make_item(REQ_INSERT, 3, 1'b1, 1'b1, 1'b0));
      send_item(make_item(REQ_INSERT, 17, 1'b0, 1'b0, 1'b0));
      send_item(make_item(REQ_INSERT, 4, 1'b1, 1'b0, 1'b1));
      send_item(make_item(REQ_WORD,   5, 1'b1, 1'b0, 1'b1));
      send_item(make_item(REQ_INSERT, 6, 1'b1, 1'b1, 1'b0));
      send_item(make_item(REQ_INSERT, 7, 1'b1, 1'b0, 1'b1));

      send_random(RANDOM_ITEMS, 1'b1);

      send_item(make_item(REQ_INSERT, 0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(REQ_WORD,   0, 1'b0, 1'b1, 1'b1));
      req_valid = 1'b0;

      while (mirror.pending() != 0) @(negedge clock);
      repeat (16) @(negedge clock);

      $display("covered %0d request transfers and %0d responses (%0d hits, %0d table full)",
               item_count, mirror.answers_total, mirror.found_total, mirror.full_total);
      $display("trie grew to %0d nodes; %0d responses at the saturated end count",
               mirror.nodes_used + 1, mirror.saturated_total);
      if (mirror.mismatches == 0) begin
         $display("trie_insert_and_lookup_unit regression: pass");
      end else begin
         $display("%0d mismatches", mirror.mismatches);
         $display("trie_insert_and_lookup_unit regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
